// ===== sv/image_projection_profile_core_defines.svh =====
// Assertion macros shared by the image projection profile RTL.
`ifndef IMAGE_PROJECTION_PROFILE_CORE_DEFINES_SVH
`define IMAGE_PROJECTION_PROFILE_CORE_DEFINES_SVH

// Clocked assertion, disabled while reset is asserted.
`define IPP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked implication, disabled while reset is asserted.
`define IPP_ASSERT_IMPL(label, cond, prop, msg) \
    `IPP_ASSERT(label, (cond) |-> (prop), msg)

`endif

// ===== sv/ipp_pkg.sv =====
// Shared types and constants of the image projection profile core.
`timescale 1ns / 1ps

package ipp_pkg;

    localparam int PIX_W  = 8;
    localparam int IDX_W  = 11;
    localparam int SUM_W  = 19;
    localparam int DIM_W  = 12;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 12'd480;

    typedef logic [1:0] reg_idx_t;

    localparam reg_idx_t REG_COLUMN_MODE  = 2'd0;
    localparam reg_idx_t REG_FRAME_WIDTH  = 2'd1;
    localparam reg_idx_t REG_FRAME_HEIGHT = 2'd2;

    typedef struct packed {
        logic             column_mode;
        logic [DIM_W-1:0] frame_width;
        logic [DIM_W-1:0] frame_height;
    } cfg_t;

endpackage

// ===== sv/image_projection_profile_core.sv =====
// Image projection profile core: per-column or per-row pixel sums of a frame.
// Path from pixel transaction to result: memory read into stage 1, then add into the output register.
// Throughput: one pixel per cycle unless a held result stalls stage 1; the column
// read-modify-write is forwarded when the same column is written back in the cycle it is read.
// Reset: synchronous active-low aresetn clears positions, row sum, valids and registers;
// the column memory is not cleared, the first row of each frame loads it.
`timescale 1ns / 1ps
`include "image_projection_profile_core_defines.svh"

module image_projection_profile_core #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ipp_pkg::ADDR_W-1:0]  paddr,
    input  logic [ipp_pkg::DATA_W-1:0]  pwdata,
    output logic [ipp_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [ipp_pkg::PIX_W-1:0]   s_pixel_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [ipp_pkg::IDX_W-1:0]   m_profile_index,
    output logic [ipp_pkg::SUM_W-1:0]   m_profile_sum,
    output logic                        m_frame_done
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int WSZ  = $clog2(MAX_WIDTH + 1);
    localparam int HSZ  = $clog2(MAX_HEIGHT + 1);
    localparam int WCMP = (WSZ > ipp_pkg::DIM_W) ? WSZ : ipp_pkg::DIM_W;
    localparam int HCMP = (HSZ > ipp_pkg::DIM_W) ? HSZ : ipp_pkg::DIM_W;
    localparam int CSW  = $clog2(255 * MAX_HEIGHT + 1);
    localparam int RSW  = $clog2(255 * MAX_WIDTH + 1);
    localparam int AW   = (CSW > RSW) ? CSW : RSW;
    localparam int XW   = (AW > ipp_pkg::SUM_W) ? AW : ipp_pkg::SUM_W + 1;
    localparam int IXT  = (CW > RW) ? CW : RW;
    localparam int IXW  = (IXT > ipp_pkg::IDX_W) ? IXT : ipp_pkg::IDX_W;

    ipp_pkg::cfg_t cfg;
    logic          restart;

    ipp_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .restart (restart)
    );

    // effective frame size
    logic [WSZ-1:0] w_eff, w_m1_full;
    logic [HSZ-1:0] h_eff, h_m1_full;
    logic [CW-1:0]  w_m1;
    logic [RW-1:0]  h_m1;

    always_comb begin
        if (cfg.frame_width == '0) begin
            w_eff = WSZ'(1);
        end else if (WCMP'(cfg.frame_width) > WCMP'(MAX_WIDTH)) begin
            w_eff = WSZ'(MAX_WIDTH);
        end else begin
            w_eff = WSZ'(cfg.frame_width);
        end
        if (cfg.frame_height == '0) begin
            h_eff = HSZ'(1);
        end else if (HCMP'(cfg.frame_height) > HCMP'(MAX_HEIGHT)) begin
            h_eff = HSZ'(MAX_HEIGHT);
        end else begin
            h_eff = HSZ'(cfg.frame_height);
        end
    end

    assign w_m1_full = w_eff - WSZ'(1);
    assign h_m1_full = h_eff - HSZ'(1);
    assign w_m1      = w_m1_full[CW-1:0];
    assign h_m1      = h_m1_full[RW-1:0];

    // position and row sum state
    logic [CW-1:0]  col_pos_reg, col_pos_next;
    logic [RW-1:0]  row_pos_reg, row_pos_next;
    logic [RSW-1:0] row_sum_reg, row_sum_next;
    logic [RSW-1:0] row_acc;
    logic           last_col, last_row;
    logic           accept;

    // stage 1 (memory data valid)
    logic                      s1_valid_reg, s1_valid_next;
    logic [CW-1:0]             s1_col_reg;
    logic [RW-1:0]             s1_row_reg;
    logic [ipp_pkg::PIX_W-1:0] s1_pix_reg;
    logic                      s1_first_row_reg;
    logic                      s1_emit_reg;
    logic                      s1_done_reg;
    logic [RSW-1:0]            s1_row_acc_reg;
    logic                      s1_advance;
    logic                      fwd_reg, fwd_next;
    logic [CSW-1:0]            fwd_data_reg;

    // output register
    logic                      out_valid_reg, out_valid_next;
    logic [ipp_pkg::IDX_W-1:0] out_idx_reg;
    logic [ipp_pkg::SUM_W-1:0] out_sum_reg;
    logic                      out_done_reg;

    logic [CSW-1:0] mem_rd_data;
    logic [CSW-1:0] col_base;
    logic [CSW-1:0] col_acc;
    logic           mem_wr_en;
    logic [AW-1:0]  sum_sel;
    logic [XW-1:0]  sum_ext;
    logic [ipp_pkg::SUM_W-1:0] sum_sat;
    logic [IXW-1:0] idx_ext;

    assign last_col = (col_pos_reg == w_m1);
    assign last_row = (row_pos_reg == h_m1);

    assign s1_advance = s1_valid_reg && (!s1_emit_reg || !out_valid_reg || m_ready);
    assign s_ready    = !s1_valid_reg || s1_advance;
    assign accept     = s_valid && s_ready;
    assign row_acc    = row_sum_reg + RSW'(s_pixel_value);

    assign mem_wr_en = s1_advance && cfg.column_mode;
    assign fwd_next  = mem_wr_en && (s1_col_reg == col_pos_reg);

    ipp_col_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW),
        .DW    (CSW)
    ) u_mem (
        .aclk    (aclk),
        .rd_en   (accept && cfg.column_mode),
        .rd_addr (col_pos_reg),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (s1_col_reg),
        .wr_data (col_acc)
    );

    assign col_base = fwd_reg ? fwd_data_reg : mem_rd_data;
    assign col_acc  = s1_first_row_reg ? CSW'(s1_pix_reg) : col_base + CSW'(s1_pix_reg);
    assign sum_sel  = cfg.column_mode ? AW'(col_acc) : AW'(s1_row_acc_reg);
    assign sum_ext  = XW'(sum_sel);
    assign sum_sat  = (sum_ext > XW'(ipp_pkg::SUM_MAX)) ? ipp_pkg::SUM_MAX
                                                        : sum_ext[ipp_pkg::SUM_W-1:0];
    assign idx_ext  = cfg.column_mode ? IXW'(s1_col_reg) : IXW'(s1_row_reg);

    always_comb begin
        col_pos_next = col_pos_reg;
        row_pos_next = row_pos_reg;
        row_sum_next = row_sum_reg;
        if (restart) begin
            col_pos_next = '0;
            row_pos_next = '0;
            row_sum_next = '0;
        end else if (accept) begin
            if (last_col) begin
                col_pos_next = '0;
                row_pos_next = last_row ? '0 : row_pos_reg + RW'(1);
                row_sum_next = '0;
            end else begin
                col_pos_next = col_pos_reg + CW'(1);
                if (!cfg.column_mode) begin
                    row_sum_next = row_acc;
                end
            end
        end
    end

    always_comb begin
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_advance) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end
        if (s1_advance && s1_emit_reg) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_pos_reg   <= '0;
            row_pos_reg   <= '0;
            row_sum_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_reg       <= 1'b0;
        end else begin
            col_pos_reg   <= col_pos_next;
            row_pos_reg   <= row_pos_next;
            row_sum_reg   <= row_sum_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (accept) begin
                fwd_reg <= fwd_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_col_reg       <= col_pos_reg;
            s1_row_reg       <= row_pos_reg;
            s1_pix_reg       <= s_pixel_value;
            s1_first_row_reg <= (row_pos_reg == '0);
            s1_emit_reg      <= cfg.column_mode ? last_row : last_col;
            s1_done_reg      <= last_col && last_row;
            s1_row_acc_reg   <= row_acc;
            fwd_data_reg     <= col_acc;
        end
        if (s1_advance && s1_emit_reg) begin
            out_idx_reg  <= idx_ext[ipp_pkg::IDX_W-1:0];
            out_sum_reg  <= sum_sat;
            out_done_reg <= s1_done_reg;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_profile_index = out_idx_reg;
    assign m_profile_sum   = out_sum_reg;
    assign m_frame_done    = out_done_reg;

    `IPP_ASSERT_IMPL(a_stall_blocks_input, s1_valid_reg && !s1_advance, !s_ready,
        "input accepted while stage 1 is stalled")
    `IPP_ASSERT(a_col_in_frame, col_pos_reg <= w_m1, "column position beyond frame width")
    `IPP_ASSERT(a_row_in_frame, row_pos_reg <= h_m1, "row position beyond frame height")
    `IPP_ASSERT_IMPL(a_fwd_column_mode, s1_valid_reg && fwd_reg, cfg.column_mode,
        "forwarded accumulator outside column mode")

endmodule

// ===== sv/ipp_cfg_regs.sv =====
// APB configuration registers of the image projection profile core.
`timescale 1ns / 1ps

module ipp_cfg_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ipp_pkg::ADDR_W-1:0] paddr,
    input  logic [ipp_pkg::DATA_W-1:0] pwdata,
    output logic [ipp_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output ipp_pkg::cfg_t              cfg,
    output logic                       restart
);

    ipp_pkg::cfg_t     cfg_reg;
    ipp_pkg::reg_idx_t reg_idx;
    logic              wr_en;
    logic              wr_hit;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_comb begin
        wr_hit = 1'b0;
        prdata = '0;
        unique case (reg_idx)
            ipp_pkg::REG_COLUMN_MODE: begin
                wr_hit = wr_en;
                prdata = ipp_pkg::DATA_W'(cfg_reg.column_mode);
            end
            ipp_pkg::REG_FRAME_WIDTH: begin
                wr_hit = wr_en;
                prdata = ipp_pkg::DATA_W'(cfg_reg.frame_width);
            end
            ipp_pkg::REG_FRAME_HEIGHT: begin
                wr_hit = wr_en;
                prdata = ipp_pkg::DATA_W'(cfg_reg.frame_height);
            end
            default: begin
                wr_hit = 1'b0;
                prdata = '0;
            end
        endcase
    end

    assign restart = wr_hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.column_mode  <= 1'b1;
            cfg_reg.frame_width  <= ipp_pkg::WIDTH_RESET;
            cfg_reg.frame_height <= ipp_pkg::HEIGHT_RESET;
        end else if (wr_hit) begin
            unique case (reg_idx)
                ipp_pkg::REG_COLUMN_MODE:  cfg_reg.column_mode  <= pwdata[0];
                ipp_pkg::REG_FRAME_WIDTH:  cfg_reg.frame_width  <= pwdata[ipp_pkg::DIM_W-1:0];
                ipp_pkg::REG_FRAME_HEIGHT: cfg_reg.frame_height <= pwdata[ipp_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

// ===== sv/ipp_col_mem.sv =====
// Column accumulator memory, one write port and one registered read port.
`timescale 1ns / 1ps

module ipp_col_mem #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11,
    parameter int DW    = 20
) (
    input  logic          aclk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    assign rd_data = rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the image projection profile core (row and column sums).
`timescale 1ns / 1ps

module tb;

    localparam int MAX_W  = 2048;
    localparam int MAX_H  = 2048;
    localparam int ACC_W  = 20;
    localparam int COL_IW = $clog2(MAX_W);

    typedef struct packed {
        logic [ipp_pkg::IDX_W-1:0] prof_index;
        logic [ipp_pkg::SUM_W-1:0] prof_sum;
        logic                      last_of_frame;
    } profile_t;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [ipp_pkg::ADDR_W-1:0]  paddr = '0;
    logic [ipp_pkg::DATA_W-1:0]  pwdata = '0;
    logic [ipp_pkg::DATA_W-1:0]  prdata;
    logic                        pready;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic [ipp_pkg::PIX_W-1:0]   s_pixel_value = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic [ipp_pkg::IDX_W-1:0]   m_profile_index;
    logic [ipp_pkg::SUM_W-1:0]   m_profile_sum;
    logic                        m_frame_done;

    image_projection_profile_core #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pixel_value   (s_pixel_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_profile_index (m_profile_index),
        .m_profile_sum   (m_profile_sum),
        .m_frame_done    (m_frame_done)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Profile predictor state
    ipp_pkg::cfg_t    prof_cfg = '{column_mode: 1'b1, frame_width: ipp_pkg::WIDTH_RESET,
                                   frame_height: ipp_pkg::HEIGHT_RESET};
    logic [ACC_W-1:0] col_acc [MAX_W];
    logic [ACC_W-1:0] row_acc = '0;
    int unsigned      col_pos = 0;
    int unsigned      row_pos = 0;

    logic [ipp_pkg::PIX_W-1:0] pixel_q[$];
    profile_t                  profile_q[$];

    bit          idle_on = 1'b1;
    int unsigned long_holds_req = 0;
    int unsigned long_holds_done = 0;
    int unsigned src_gap = 0;
    int unsigned sink_gap = 0;
    int unsigned fail_count = 0;
    int unsigned pixels_seen = 0;
    int unsigned sums_seen = 0;
    int unsigned frames_seen = 0;

    function automatic int unsigned eff_size(input logic [ipp_pkg::DIM_W-1:0] v,
                                             input int unsigned lim);
        if (v == '0)
            return 1;
        if (32'(v) > lim)
            return lim;
        return 32'(v);
    endfunction

    function automatic void predict_profile(input logic [ipp_pkg::PIX_W-1:0] pix);
        int unsigned      w;
        int unsigned      h;
        int unsigned      col;
        int unsigned      row;
        logic [ACC_W-1:0] acc;
        profile_t         r;
        bit               emit;
        w = eff_size(prof_cfg.frame_width, MAX_W);
        h = eff_size(prof_cfg.frame_height, MAX_H);
        col = (col_pos >= w) ? w - 1 : col_pos;
        row = (row_pos >= h) ? h - 1 : row_pos;
        emit = 1'b0;
        r = '0;
        if (prof_cfg.column_mode) begin
            acc = (row == 0) ? ACC_W'(pix) : col_acc[col[COL_IW-1:0]] + ACC_W'(pix);
            col_acc[col[COL_IW-1:0]] = acc;
            if (row == h - 1) begin
                emit = 1'b1;
                r.prof_index = col[ipp_pkg::IDX_W-1:0];
                r.last_of_frame = (col == w - 1);
            end
        end else begin
            acc = row_acc + ACC_W'(pix);
            if (col == w - 1) begin
                emit = 1'b1;
                r.prof_index = row[ipp_pkg::IDX_W-1:0];
                r.last_of_frame = (row == h - 1);
                row_acc = '0;
            end else begin
                row_acc = acc;
            end
        end
        if (col == w - 1) begin
            col_pos = 0;
            row_pos = (row == h - 1) ? 0 : row + 1;
            if (row == h - 1)
                row_acc = '0;
        end else begin
            col_pos = col + 1;
            row_pos = row;
        end
        if (emit) begin
            r.prof_sum = (acc > ipp_pkg::SUM_MAX) ? ipp_pkg::SUM_MAX
                                                  : acc[ipp_pkg::SUM_W-1:0];
            profile_q.push_back(r);
        end
    endfunction

    // Pixel driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap = 0;
        end else if (!s_valid || s_ready) begin
            if (src_gap > 0) begin
                src_gap--;
                s_valid <= 1'b0;
            end else if (pixel_q.size() > 0) begin
                s_valid <= 1'b1;
                s_pixel_value <= pixel_q.pop_front();
                if (idle_on && $urandom_range(0, 9) == 0)
                    src_gap = $urandom_range(1, 19);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result-side ready, with random stalls and requested long holds
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_gap = 0;
        end else if (long_holds_done != long_holds_req) begin
            long_holds_done++;
            sink_gap = 399;
            m_ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            sink_gap = $urandom_range(0, 18);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Monitor: predict on pixel transactions, check result transactions
    always @(posedge aclk) begin
        profile_t exp_r;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_profile(s_pixel_value);
                pixels_seen++;
            end
            if (m_valid && m_ready) begin
                sums_seen++;
                if (m_frame_done)
                    frames_seen++;
                if (profile_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result index %0d sum %0d done %0b", $time,
                             m_profile_index, m_profile_sum, m_frame_done);
                end else begin
                    exp_r = profile_q.pop_front();
                    if (m_profile_index !== exp_r.prof_index) begin
                        fail_count++;
                        $display("%0t: profile_index expected %0d actual %0d", $time,
                                 exp_r.prof_index, m_profile_index);
                    end
                    if (m_profile_sum !== exp_r.prof_sum) begin
                        fail_count++;
                        $display("%0t: profile_sum expected %0d actual %0d", $time,
                                 exp_r.prof_sum, m_profile_sum);
                    end
                    if (m_frame_done !== exp_r.last_of_frame) begin
                        fail_count++;
                        $display("%0t: frame_done expected %0b actual %0b", $time,
                                 exp_r.last_of_frame, m_frame_done);
                    end
                end
            end
        end
    end

    task automatic wait_idle();
        do
            @(negedge aclk);
        while (pixel_q.size() != 0 || s_valid || profile_q.size() != 0);
        // column mode can leave pixels in flight with no result pending
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input ipp_pkg::reg_idx_t idx,
                             input logic [ipp_pkg::DATA_W-1:0] val);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            ipp_pkg::REG_COLUMN_MODE:  prof_cfg.column_mode = val[0];
            ipp_pkg::REG_FRAME_WIDTH:  prof_cfg.frame_width = val[ipp_pkg::DIM_W-1:0];
            ipp_pkg::REG_FRAME_HEIGHT: prof_cfg.frame_height = val[ipp_pkg::DIM_W-1:0];
            default: ;
        endcase
        row_acc = '0;
        col_pos = 0;
        row_pos = 0;
    endtask

    task automatic configure(input logic mode, input logic [ipp_pkg::DIM_W-1:0] w,
                             input logic [ipp_pkg::DIM_W-1:0] h);
        wait_idle();
        write_reg(ipp_pkg::REG_COLUMN_MODE, ipp_pkg::DATA_W'(mode));
        write_reg(ipp_pkg::REG_FRAME_WIDTH, ipp_pkg::DATA_W'(w));
        write_reg(ipp_pkg::REG_FRAME_HEIGHT, ipp_pkg::DATA_W'(h));
        @(negedge aclk);
    endtask

    // fill < 0 gives random pixels biased toward the extremes
    task automatic queue_pixels(input int unsigned n, input int fill);
        repeat (n) begin
            if (fill >= 0)
                pixel_q.push_back(fill[ipp_pkg::PIX_W-1:0]);
            else case ($urandom_range(0, 7))
                0:       pixel_q.push_back('0);
                1:       pixel_q.push_back('1);
                default: pixel_q.push_back(ipp_pkg::PIX_W'($urandom_range(0, 255)));
            endcase
        end
    endtask

    initial begin
        int unsigned w;
        int unsigned h;
        int unsigned n;
        int unsigned area;
        int unsigned rand_items;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        configure(1'b1, 12'd3, 12'd2);
        pixel_q = '{8'd0, 8'd255, 8'd1, 8'd128, 8'd127, 8'd254};
        configure(1'b0, 12'd4, 12'd2);
        queue_pixels(4, 255);
        queue_pixels(4, 0);
        configure(1'b1, 12'd0, 12'd0);
        pixel_q = '{8'h55, 8'haa};
        // mid-frame register writes restart the frame
        configure(1'b1, 12'd3, 12'd3);
        queue_pixels(4, -1);
        wait_idle();
        write_reg(ipp_pkg::REG_FRAME_HEIGHT, ipp_pkg::DATA_W'(3));
        @(negedge aclk);
        queue_pixels(9, -1);
        configure(1'b0, 12'd5, 12'd2);
        queue_pixels(3, -1);
        wait_idle();
        write_reg(ipp_pkg::REG_COLUMN_MODE, ipp_pkg::DATA_W'(0));
        @(negedge aclk);
        queue_pixels(10, -1);

        // oversized frame registers, clamped to the maximum
        configure(1'b1, 12'd4095, 12'd1);
        queue_pixels(20, 255);
        configure(1'b0, 12'd1, 12'd4095);
        queue_pixels(20, -1);

        // long receiver hold while pixels keep coming
        configure(1'b1, 12'd8, 12'd1);
        queue_pixels(40, -1);
        long_holds_req++;

        rand_items = 0;
        while (rand_items < 250) begin
            idle_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0:       w = 0;
                1:       w = $urandom_range(13, 64);
                default: w = $urandom_range(1, 12);
            endcase
            h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
            configure(1'($urandom_range(0, 1)), w[ipp_pkg::DIM_W-1:0],
                      h[ipp_pkg::DIM_W-1:0]);
            area = eff_size(w[ipp_pkg::DIM_W-1:0], MAX_W) *
                   eff_size(h[ipp_pkg::DIM_W-1:0], MAX_H);
            n = area * $urandom_range(1, 2) + $urandom_range(0, area - 1);
            if (n > 60)
                n = $urandom_range(20, 60);
            queue_pixels(n, -1);
            rand_items += n;
        end

        idle_on = 1'b0;
        configure(1'b1, 12'd5, 12'd3);
        queue_pixels(30, -1);
        configure(1'b0, 12'd6, 12'd4);
        queue_pixels(24, -1);
        wait_idle();

        $display("Covered %0d pixels and %0d profile sums (%0d complete frames) in row and",
                 pixels_seen, sums_seen, frames_seen);
        $display("column mode, sizes from 1 up to clamped oversize, with restarts and stalls");
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("Timeout waiting for the profile results");
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/ipp_pkg.sv
sv/ipp_cfg_regs.sv
sv/ipp_col_mem.sv
sv/image_projection_profile_core.sv
verif/tb.sv
